// File: rtl/pixel_depth_to_world_point_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-to-world point pipeline
// Clocked implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PIXEL_DEPTH_TO_WORLD_POINT_ASSERT_SVH
`define PIXEL_DEPTH_TO_WORLD_POINT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdw check failed");
// next-cycle implication
`define PDW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdw check failed");
`else
`define PDW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pdw_pkg.sv
// ----------------------------------------------------------------------------
// pdw_pkg
// Shared widths, latencies, mount constants and types of the point pipeline.
// ----------------------------------------------------------------------------
package pdw_pkg;

    localparam int DEPTH_W   = 32;
    localparam int POSE_W    = 32;
    localparam int QUAT_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 8;
    localparam int COORD_W   = 32;
    localparam int CAM_W     = DEPTH_W + 2;   // sign + 33-bit magnitude
    localparam int ROT_W     = 32;            // Q.28 rotation entries

    localparam int MNT_SHIFT = 29;
    localparam int ROT_SHIFT = 28;

    localparam int DIV_STEPS = DEPTH_W + 1;   // quotient bits
    localparam int CAM_LAT   = DIV_STEPS + 5;
    localparam int MNT_LAT   = 3;
    localparam int ROT_LAT   = 5;
    localparam int TOT_LAT   = CAM_LAT + MNT_LAT + ROT_LAT;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam logic signed [QUAT_W-1:0] Q_ONE = 16'sd16384;

    localparam logic [CFG_W-1:0] FOCAL_X_RST  = 32'd59720192;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 32'd59736680;
    localparam logic [CFG_W-1:0] CENTER_X_RST = 32'd41890128;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 32'd23673110;

    // camera-to-body mount, Q.29
    localparam logic signed [31:0] MOUNT_ROT [3][3] = '{
        '{ 32'sd18369629,  -32'sd179646671, -32'sd505588518},
        '{ 32'sd536550400,  32'sd8561856,    32'sd16452302},
        '{ 32'sd2557728,   -32'sd505849974,  32'sd179832428}
    };
    localparam logic signed [31:0] MOUNT_OFF [3] = '{
        32'sd304407418, -32'sd9700721, 32'sd9387134
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 0,
        CFG_FOCAL_Y  = 1,
        CFG_CENTER_X = 2,
        CFG_CENTER_Y = 3
    } t_cfg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [DEPTH_W-1:0]        depth;
        logic signed [POSE_W-1:0]  pose_x;
        logic signed [POSE_W-1:0]  pose_y;
        logic signed [POSE_W-1:0]  pose_z;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
    } t_side;

    function automatic logic signed [QUAT_W-1:0] clamp_quat(
        input logic signed [QUAT_W-1:0] q
    );
        logic signed [QUAT_W-1:0] r;
        r = q;
        if (q > Q_ONE) begin
            r = Q_ONE;
        end else if (q < -Q_ONE) begin
            r = -Q_ONE;
        end
        return r;
    endfunction

endpackage

// File: rtl/pixel_depth_to_world_point.sv
// ----------------------------------------------------------------------------
// pixel_depth_to_world_point
// Pixel plus depth to world point: pinhole back projection, fixed camera
// mount, quaternion pose transform, saturated Q.FRAC_BITS outputs.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is accepted every cycle while the pipeline is not
// frozen, and each result passes through the camera axes (dominated by the
// 33-stage one-bit-per-stage divider by the focal length), the mount
// transform, and the rotation and pose add. The whole pipeline advances
// together; it freezes only while a result sits in the output register and
// the sink stalls, so o_stall is high exactly then. Focal length and center
// registers are read live by the pipeline and are to be written only while
// no beat is in flight; the config port is always ready. Quaternion parts
// outside +-1.0 are clamped; the quaternion is not normalized.
`include "pixel_depth_to_world_point_assert.svh"

module pixel_depth_to_world_point
    import pdw_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int PIXEL_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input beat
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [PIXEL_BITS-1:0]    i_pixel_column,
    input  logic [PIXEL_BITS-1:0]    i_pixel_row,
    input  logic [DEPTH_W-1:0]       i_depth,
    input  logic signed [POSE_W-1:0] i_pose_x,
    input  logic signed [POSE_W-1:0] i_pose_y,
    input  logic signed [POSE_W-1:0] i_pose_z,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    // result beat
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [COORD_W-1:0] o_world_x,
    output logic signed [COORD_W-1:0] o_world_y,
    output logic signed [COORD_W-1:0] o_world_z,
    output logic                     o_saturated,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int SIDE_LAT = CAM_LAT + MNT_LAT;

    logic ce;
    assign ce          = !o_valid || !i_stall;
    assign o_stall     = !ce;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [CFG_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;    // unknown index: write dropped
            endcase
        end
    end

    // valid bits, one per pipeline stage
    logic [TOT_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[TOT_LAT-1];

    // depth, pose and clamped quaternion ride alongside the camera and mount stages
    t_side n_side;
    t_side r_side [SIDE_LAT];

    always_comb begin
        n_side.depth  = i_depth;
        n_side.pose_x = i_pose_x;
        n_side.pose_y = i_pose_y;
        n_side.pose_z = i_pose_z;
        n_side.quat_w = clamp_quat(i_quat_w);
        n_side.quat_x = clamp_quat(i_quat_x);
        n_side.quat_y = clamp_quat(i_quat_y);
        n_side.quat_z = clamp_quat(i_quat_z);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // camera frame
    logic signed [CAM_W-1:0] cam_x, cam_y;
    logic                    cam_flag_x, cam_flag_y;

    pdw_cam_axis #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cam_x (
        .i_clk    (i_clk),
        .i_ce     (ce),
        .i_pix    (i_pixel_column),
        .i_depth  (i_depth),
        .i_center (r_center_x),
        .i_focal  (r_focal_x),
        .o_cam    (cam_x),
        .o_flag   (cam_flag_x)
    );

    pdw_cam_axis #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cam_y (
        .i_clk    (i_clk),
        .i_ce     (ce),
        .i_pix    (i_pixel_row),
        .i_depth  (i_depth),
        .i_center (r_center_y),
        .i_focal  (r_focal_y),
        .o_cam    (cam_y),
        .o_flag   (cam_flag_y)
    );

    // body frame
    t_coord body [3];
    logic   body_flag;

    pdw_mount #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mount (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_cam_x (cam_x),
        .i_cam_y (cam_y),
        .i_depth (r_side[CAM_LAT-1].depth),
        .i_flag  (cam_flag_x | cam_flag_y),
        .o_body  (body),
        .o_flag  (body_flag)
    );

    // world frame
    logic signed [POSE_W-1:0] pose [3];
    t_coord                   world [3];

    assign pose[0] = r_side[SIDE_LAT-1].pose_x;
    assign pose[1] = r_side[SIDE_LAT-1].pose_y;
    assign pose[2] = r_side[SIDE_LAT-1].pose_z;

    pdw_rotate u_rotate (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_body  (body),
        .i_qw    (r_side[SIDE_LAT-1].quat_w),
        .i_qx    (r_side[SIDE_LAT-1].quat_x),
        .i_qy    (r_side[SIDE_LAT-1].quat_y),
        .i_qz    (r_side[SIDE_LAT-1].quat_z),
        .i_pose  (pose),
        .i_flag  (body_flag),
        .o_world (world),
        .o_flag  (o_saturated)
    );

    assign o_world_x = world[0];
    assign o_world_y = world[1];
    assign o_world_z = world[2];

    // checks
    `PDW_ASSERT_IMP(a_zero_fx, i_clk, i_rst_n, r_vld[CAM_LAT-1] && (r_focal_x == '0), cam_flag_x && (cam_x == '0))
    `PDW_ASSERT_IMP(a_zero_fy, i_clk, i_rst_n, r_vld[CAM_LAT-1] && (r_focal_y == '0), cam_flag_y && (cam_y == '0))
    `PDW_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    `PDW_ASSERT_NXT(a_freeze_holds, i_clk, i_rst_n, !ce, $stable(r_vld))

endmodule

// File: rtl/pdw_cam_axis.sv
// ----------------------------------------------------------------------------
// pdw_cam_axis
// One camera axis: depth * (pixel - center) / focal, rounded, with a
// one-bit-per-stage pipelined restoring divider.
// ----------------------------------------------------------------------------
module pdw_cam_axis
    import pdw_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int PIXEL_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic [PIXEL_BITS-1:0]    i_pix,
    input  logic [DEPTH_W-1:0]       i_depth,
    input  logic [CFG_W-1:0]         i_center,
    input  logic [CFG_W-1:0]         i_focal,
    output logic signed [CAM_W-1:0]  o_cam,
    output logic                     o_flag
);

    localparam int SH_W   = PIXEL_BITS + FRAC_BITS;
    localparam int MAG_W  = ((SH_W > DEPTH_W) ? SH_W : DEPTH_W) + 1;
    localparam int HI_W   = MAG_W - DEPTH_W;
    localparam int P0_W   = 2 * DEPTH_W;
    localparam int P1_W   = DEPTH_W + HI_W;
    localparam int PROD_W = DEPTH_W + MAG_W;
    localparam int D_W    = MAG_W + 1;
    localparam int NUM_W  = 2 * DEPTH_W + 1;

    // stage 1: signed offset from principal point
    logic signed [D_W-1:0] s1_pix, s1_ctr, s1_diff;
    logic                  n_s1_neg;
    logic [MAG_W-1:0]      n_s1_mag;
    logic                  r_s1_neg;
    logic [MAG_W-1:0]      r_s1_mag;
    logic [DEPTH_W-1:0]    r_s1_depth;

    assign s1_pix   = signed'(D_W'({i_pix, {FRAC_BITS{1'b0}}}));
    assign s1_ctr   = signed'(D_W'(i_center));
    assign s1_diff  = s1_pix - s1_ctr;
    assign n_s1_neg = s1_diff[D_W-1];
    assign n_s1_mag = n_s1_neg ? MAG_W'(-s1_diff) : MAG_W'(s1_diff);

    // stage 2: partial products
    logic [P0_W-1:0] n_s2_p0, r_s2_p0;
    logic [P1_W-1:0] n_s2_p1, r_s2_p1;
    logic            r_s2_neg;

    assign n_s2_p0 = P0_W'(r_s1_depth) * P0_W'(r_s1_mag[DEPTH_W-1:0]);
    assign n_s2_p1 = P1_W'(r_s1_depth) * P1_W'(r_s1_mag[MAG_W-1:DEPTH_W]);

    // stage 3: full product
    logic [PROD_W-1:0] n_s3_prod, r_s3_prod;
    logic              r_s3_neg;

    assign n_s3_prod = PROD_W'(r_s2_p0) + (PROD_W'(r_s2_p1) << DEPTH_W);

    // stage 4 (divider entry): range check and rounding bias
    logic             n_s4_ovf;
    logic [NUM_W-1:0] n_s4_num;

    assign n_s4_ovf = r_s3_prod[PROD_W-1:DEPTH_W] >= MAG_W'(i_focal);
    assign n_s4_num = NUM_W'(r_s3_prod[P0_W-1:0]) + NUM_W'(i_focal >> 1);

    logic [DEPTH_W-1:0]   r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1_neg   <= n_s1_neg;
            r_s1_mag   <= n_s1_mag;
            r_s1_depth <= i_depth;
            r_s2_p0    <= n_s2_p0;
            r_s2_p1    <= n_s2_p1;
            r_s2_neg   <= r_s1_neg;
            r_s3_prod  <= n_s3_prod;
            r_s3_neg   <= r_s2_neg;
            r_rem[0]   <= n_s4_num[NUM_W-1:DIV_STEPS];
            r_low[0]   <= n_s4_num[DIV_STEPS-1:0];
            r_q[0]     <= '0;
            r_neg[0]   <= r_s3_neg;
            r_ovf[0]   <= n_s4_ovf;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [DEPTH_W:0]   trial;
        logic [DEPTH_W:0]   diff;
        logic               ge;
        logic [DEPTH_W-1:0] n_rem;

        assign trial = {r_rem[k-1], r_low[k-1][DIV_STEPS-1]};
        assign diff  = trial - {1'b0, i_focal};
        assign ge    = trial >= {1'b0, i_focal};
        assign n_rem = ge ? diff[DEPTH_W-1:0] : trial[DEPTH_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= n_rem;
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][DIV_STEPS-2:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // output stage: clip, sign, zero-focal override
    logic signed [CAM_W-1:0] n_cam;
    logic                    n_flag;

    always_comb begin
        logic [DIV_STEPS-1:0] mag;
        logic                 fz;
        logic                 big;
        fz  = (i_focal == '0);
        big = r_ovf[DIV_STEPS] | r_q[DIV_STEPS][DIV_STEPS-1];
        mag = r_q[DIV_STEPS];
        if (fz) begin
            mag = '0;
        end else if (big) begin
            mag = {1'b0, {DEPTH_W{1'b1}}};
        end
        n_flag = fz | big;
        n_cam  = r_neg[DIV_STEPS] ? -signed'(CAM_W'(mag)) : signed'(CAM_W'(mag));
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_cam  <= n_cam;
            o_flag <= n_flag;
        end
    end

endmodule

// File: rtl/pdw_mount.sv
// ----------------------------------------------------------------------------
// pdw_mount
// Camera frame to body frame through the fixed Q.29 mount transform.
// ----------------------------------------------------------------------------
module pdw_mount
    import pdw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic signed [CAM_W-1:0]  i_cam_x,
    input  logic signed [CAM_W-1:0]  i_cam_y,
    input  logic [DEPTH_W-1:0]       i_depth,
    input  logic                     i_flag,
    output t_coord                   o_body [3],
    output logic                     o_flag
);

    localparam int MP_W  = CAM_W + 32;
    localparam int ACC_W = MP_W + 2;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (MNT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'(S32_MAX);
    localparam logic signed [ACC_W-1:0] C_MIN = ACC_W'(S32_MIN);

    logic signed [CAM_W-1:0] cam [3];
    logic signed [MP_W-1:0]  n_prod [3][3];
    logic signed [MP_W-1:0]  r_prod [3][3];
    logic signed [ACC_W-1:0] n_acc [3];
    logic signed [ACC_W-1:0] r_acc [3];
    t_coord                  n_body [3];
    logic                    n_clip;
    logic                    r_flag1, r_flag2;

    assign cam[0] = i_cam_x;
    assign cam[1] = i_cam_y;
    assign cam[2] = signed'(CAM_W'(i_depth));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = MP_W'(cam[j]) * MP_W'(MOUNT_ROT[i][j]);
            end
            n_acc[i] = ACC_W'(r_prod[i][0]) + ACC_W'(r_prod[i][1])
                     + ACC_W'(r_prod[i][2]) + (ACC_W'(MOUNT_OFF[i]) <<< FRAC_BITS);
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] sh;
        n_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sh = (r_acc[i] + HALF) >>> MNT_SHIFT;
            if (sh > C_MAX) begin
                n_body[i] = COORD_W'(S32_MAX);
                n_clip    = 1'b1;
            end else if (sh < C_MIN) begin
                n_body[i] = COORD_W'(S32_MIN);
                n_clip    = 1'b1;
            end else begin
                n_body[i] = sh[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod  <= n_prod;
            r_acc   <= n_acc;
            o_body  <= n_body;
            r_flag1 <= i_flag;
            r_flag2 <= r_flag1;
            o_flag  <= r_flag2 | n_clip;
        end
    end

endmodule

// File: rtl/pdw_rotate.sv
// ----------------------------------------------------------------------------
// pdw_rotate
// Body frame to world frame: quaternion rotation matrix (Q.28), product,
// rounding, pose offset and saturation. Last stage is the output register.
// ----------------------------------------------------------------------------
module pdw_rotate
    import pdw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  t_coord                   i_body [3],
    input  logic signed [QUAT_W-1:0] i_qw,
    input  logic signed [QUAT_W-1:0] i_qx,
    input  logic signed [QUAT_W-1:0] i_qy,
    input  logic signed [QUAT_W-1:0] i_qz,
    input  logic signed [POSE_W-1:0] i_pose [3],
    input  logic                     i_flag,
    output t_coord                   o_world [3],
    output logic                     o_flag
);

    localparam int QQ_W  = 2 * QUAT_W;
    localparam int RP_W  = ROT_W + COORD_W;
    localparam int SUM_W = RP_W + 2;
    localparam logic signed [ROT_W-1:0] ONE  = ROT_W'(1) <<< ROT_SHIFT;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (ROT_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'(S32_MAX);
    localparam logic signed [SUM_W-1:0] C_MIN = SUM_W'(S32_MIN);

    // quaternion products: xx yy zz xy xz yz wx wy wz
    logic signed [QQ_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [ROT_W-1:0] n_rot [3][3];
    logic signed [ROT_W-1:0] r_rot [3][3];
    logic signed [RP_W-1:0]  n_rp [3][3];
    logic signed [RP_W-1:0]  r_rp [3][3];
    logic signed [SUM_W-1:0] n_sum [3];
    logic signed [SUM_W-1:0] r_sum [3];
    t_coord                  r_body1 [3];
    t_coord                  r_body2 [3];
    logic signed [POSE_W-1:0] r_pose1 [3];
    logic signed [POSE_W-1:0] r_pose2 [3];
    logic signed [POSE_W-1:0] r_pose3 [3];
    logic signed [POSE_W-1:0] r_pose4 [3];
    logic                    r_flag1, r_flag2, r_flag3, r_flag4;
    t_coord                  n_world [3];
    logic                    n_clip;

    always_comb begin
        n_rot[0][0] = ONE - ((r_yy + r_zz) <<< 1);
        n_rot[0][1] = (r_xy - r_wz) <<< 1;
        n_rot[0][2] = (r_xz + r_wy) <<< 1;
        n_rot[1][0] = (r_xy + r_wz) <<< 1;
        n_rot[1][1] = ONE - ((r_xx + r_zz) <<< 1);
        n_rot[1][2] = (r_yz - r_wx) <<< 1;
        n_rot[2][0] = (r_xz - r_wy) <<< 1;
        n_rot[2][1] = (r_yz + r_wx) <<< 1;
        n_rot[2][2] = ONE - ((r_xx + r_yy) <<< 1);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_rp[i][j] = RP_W'(r_rot[i][j]) * RP_W'(r_body2[j]);
            end
            n_sum[i] = SUM_W'(r_rp[i][0]) + SUM_W'(r_rp[i][1]) + SUM_W'(r_rp[i][2]);
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] w;
        n_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w = ((r_sum[i] + HALF) >>> ROT_SHIFT) + SUM_W'(r_pose4[i]);
            if (w > C_MAX) begin
                n_world[i] = COORD_W'(S32_MAX);
                n_clip     = 1'b1;
            end else if (w < C_MIN) begin
                n_world[i] = COORD_W'(S32_MIN);
                n_clip     = 1'b1;
            end else begin
                n_world[i] = w[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xx    <= QQ_W'(i_qx) * QQ_W'(i_qx);
            r_yy    <= QQ_W'(i_qy) * QQ_W'(i_qy);
            r_zz    <= QQ_W'(i_qz) * QQ_W'(i_qz);
            r_xy    <= QQ_W'(i_qx) * QQ_W'(i_qy);
            r_xz    <= QQ_W'(i_qx) * QQ_W'(i_qz);
            r_yz    <= QQ_W'(i_qy) * QQ_W'(i_qz);
            r_wx    <= QQ_W'(i_qw) * QQ_W'(i_qx);
            r_wy    <= QQ_W'(i_qw) * QQ_W'(i_qy);
            r_wz    <= QQ_W'(i_qw) * QQ_W'(i_qz);
            r_body1 <= i_body;
            r_pose1 <= i_pose;
            r_flag1 <= i_flag;
            r_rot   <= n_rot;
            r_body2 <= r_body1;
            r_pose2 <= r_pose1;
            r_flag2 <= r_flag1;
            r_rp    <= n_rp;
            r_pose3 <= r_pose2;
            r_flag3 <= r_flag2;
            r_sum   <= n_sum;
            r_pose4 <= r_pose3;
            r_flag4 <= r_flag3;
            o_world <= n_world;
            o_flag  <= r_flag4 | n_clip;
        end
    end

endmodule
